[rtl/core/ltmb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the luma threshold mask and bounding box block.
// No dependencies; imported by the channel interfaces and the top level.
package ltmb_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned ChanBits  = 8;
  localparam int unsigned ThrBits   = 9;
  // 100 * 255 for the luma and 100 * 511 for the scaled threshold fit in 16 bits
  localparam int unsigned LumaBits  = 16;

  localparam logic [LumaBits-1:0] WeightRed   = LumaBits'(30);
  localparam logic [LumaBits-1:0] WeightGreen = LumaBits'(59);
  localparam logic [LumaBits-1:0] WeightBlue  = LumaBits'(11);
  localparam logic [LumaBits-1:0] LumaScale   = LumaBits'(100);

  localparam logic [ThrBits-1:0] ThrReset = ThrBits'(128);

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [ChanBits-1:0]  chan_t;
  typedef logic [LumaBits-1:0]  luma_t;

  typedef struct packed {
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    coord_t column;
    coord_t row;
    logic   frame_start;
    logic   frame_end;
  } pix_t;

  typedef struct packed {
    logic   mask_bit;
    coord_t box_min_column;
    coord_t box_min_row;
    coord_t box_max_column;
    coord_t box_max_row;
    logic   box_found;
    logic   last_of_frame;
  } res_t;

  typedef struct packed {
    coord_t min_column;
    coord_t min_row;
    coord_t max_column;
    coord_t max_row;
    logic   found;
  } box_t;

endpackage

[rtl/core/ltmb_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel requests in, mask and box results out.
// Depends on ltmb_pkg for field widths.
interface ltmb_pix_if
  import ltmb_pkg::*;
();
  logic   valid;
  logic   ready;
  chan_t  red;
  chan_t  green;
  chan_t  blue;
  coord_t column;
  coord_t row;
  logic   frame_start;
  logic   frame_end;

  modport source (output valid, red, green, blue, column, row, frame_start, frame_end,
                  input ready);
  modport sink   (input valid, red, green, blue, column, row, frame_start, frame_end,
                  output ready);
endinterface

interface ltmb_res_if
  import ltmb_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   mask_bit;
  coord_t box_min_column;
  coord_t box_min_row;
  coord_t box_max_column;
  coord_t box_max_row;
  logic   box_found;
  logic   last_of_frame;

  modport source (output valid, mask_bit, box_min_column, box_min_row, box_max_column,
                  box_max_row, box_found, last_of_frame, input ready);
  modport sink   (input valid, mask_bit, box_min_column, box_min_row, box_max_column,
                  box_max_row, box_found, last_of_frame, output ready);
endinterface

[rtl/core/luma_threshold_mask_bbox.sv]
`timescale 1ns / 1ps
// Top level: luma threshold mask with running bounding box of foreground pixels.
// Depends on ltmb_pkg and the channel interfaces in ltmb_if.sv.
//
// Usage:
//   pix_i carries one RGB pixel per request with its column, row and frame marks.
//   res_o returns one result per pixel: the mask bit (scaled luma 30R+59G+11B at
//   or above 100 times the threshold) and the box as it stands after that pixel.
//   The result with last_of_frame set carries the final box of the frame.
//   cfg_we_i / cfg_data_i write the 9-bit luma threshold; write only when idle.
//   From acceptance a pixel passes an input register, then the luma compare and
//   min/max update feeding the result register.
//   Throughput is one pixel per cycle while res_o is taken; the box update is
//   combinational between the input register and the result register.
//   If the receiver stalls, the result register holds and the input register
//   takes a request only while it is empty; once full, pix_i.ready drops.
//   Reset empties both registers, sets the threshold to 128 and clears the box.
module luma_threshold_mask_bbox
  import ltmb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ThrBits-1:0]  cfg_data_i,
  ltmb_pix_if.sink            pix_i,
  ltmb_res_if.source          res_o
);

  logic [ThrBits-1:0] thr_q;
  logic               in_vld_q;
  pix_t               in_q;
  logic               out_vld_q;
  res_t               out_q, out_d;
  box_t               box_q, box_d;

  logic  out_free;
  logic  in_take;
  logic  adv;
  luma_t luma;
  luma_t thr_scaled;
  logic  fg;
  box_t  base;

  assign out_free    = !out_vld_q || res_o.ready;
  assign adv         = in_vld_q && out_free;
  assign pix_i.ready = !in_vld_q || out_free;
  assign in_take     = pix_i.valid && pix_i.ready;

  assign luma = WeightRed * LumaBits'(in_q.red) + WeightGreen * LumaBits'(in_q.green)
              + WeightBlue * LumaBits'(in_q.blue);
  assign thr_scaled = LumaScale * LumaBits'(thr_q);
  assign fg = (luma >= thr_scaled);

  always_comb begin
    // frame start clears the box before this pixel is taken in
    if (in_q.frame_start) begin
      base = '{min_column: '1, min_row: '1, max_column: '0, max_row: '0, found: 1'b0};
    end else begin
      base = box_q;
    end
    box_d = base;
    if (fg) begin
      if (in_q.column < base.min_column) box_d.min_column = in_q.column;
      if (in_q.row < base.min_row)       box_d.min_row    = in_q.row;
      if (in_q.column > base.max_column) box_d.max_column = in_q.column;
      if (in_q.row > base.max_row)       box_d.max_row    = in_q.row;
      box_d.found = 1'b1;
    end
    out_d.mask_bit      = fg;
    out_d.box_found     = box_d.found;
    out_d.last_of_frame = in_q.frame_end;
    if (box_d.found) begin
      out_d.box_min_column = box_d.min_column;
      out_d.box_min_row    = box_d.min_row;
      out_d.box_max_column = box_d.max_column;
      out_d.box_max_row    = box_d.max_row;
    end else begin
      out_d.box_min_column = '0;
      out_d.box_min_row    = '0;
      out_d.box_max_column = '0;
      out_d.box_max_row    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThrReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      box_q     <= '{min_column: '1, min_row: '1, max_column: '0, max_row: '0,
                     found: 1'b0};
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (pix_i.ready) in_vld_q <= pix_i.valid;
      if (out_free) out_vld_q <= in_vld_q;
      if (adv) box_q <= box_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= '{red: pix_i.red, green: pix_i.green, blue: pix_i.blue,
                column: pix_i.column, row: pix_i.row,
                frame_start: pix_i.frame_start, frame_end: pix_i.frame_end};
    end
    if (adv) out_q <= out_d;
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.mask_bit       = out_q.mask_bit;
  assign res_o.box_min_column = out_q.box_min_column;
  assign res_o.box_min_row    = out_q.box_min_row;
  assign res_o.box_max_column = out_q.box_max_column;
  assign res_o.box_max_row    = out_q.box_max_row;
  assign res_o.box_found      = out_q.box_found;
  assign res_o.last_of_frame  = out_q.last_of_frame;

endmodule
